/* src/pac_pkg.sv */
// Types, codes and shared arithmetic for the pixel alpha compositor.
`default_nettype none
package pac_pkg;

  localparam int unsigned FullScale = 255;

  // Reciprocal of 255 scaled by 2^23, exact for every 16-bit dividend.
  localparam logic [31:0] Recip255 = 32'h0000_8081;
  // Reciprocal of 255*255 scaled by 2^32, rounded up; the quotient may be high by one.
  localparam logic [40:0] Recip65025 = 41'd66052;
  localparam logic [24:0] FullScaleSq = 25'd65025;

  localparam logic [7:0] OpacityReset = 8'd255;

  typedef enum logic [1:0] {
    KIND_PAINT         = 2'd0,
    KIND_COPY          = 2'd1,
    KIND_MASK_SOLID    = 2'd2,
    KIND_MASK_SAMPLED  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] mask_alpha;
    logic [7:0] dest_red;
    logic [7:0] dest_green;
    logic [7:0] dest_blue;
    logic [7:0] dest_alpha;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       changed;
  } pixel_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // Handed from the alpha stages to the blend stages.
  typedef struct packed {
    rgba_t      src;
    rgba_t      dest;
    logic [7:0] alpha;
    logic       active;
  } alpha_t;

  // Truncating divide by 255 for dividends below 2^16.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * Recip255;
    return p[30:23];
  endfunction

endpackage
`default_nettype wire

/* src/pac_pix_in_if.sv */
// Stream interface for incoming pixel pairs.
`default_nettype none
interface pac_pix_in_if;
  logic               valid;
  logic               ready;
  pac_pkg::pixel_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/pac_pix_out_if.sv */
// Stream interface for composited pixels.
`default_nettype none
interface pac_pix_out_if;
  logic                valid;
  logic                ready;
  pac_pkg::pixel_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/pac_cfg.sv */
// APB register port holding the global opacity level.
`default_nettype none
module pac_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [7:0]  opacity_o
);

  logic [7:0] opacity_q;
  logic [7:0] opacity_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr == 2'd0);

  always_comb begin
    opacity_d = opacity_q;
    if (wr_en) begin
      opacity_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q <= pac_pkg::OpacityReset;
    end else begin
      opacity_q <= opacity_d;
    end
  end

  assign prdata    = (paddr == 2'd0) ? {24'd0, opacity_q} : 32'd0;
  assign opacity_o = opacity_q;

endmodule
`default_nettype wire

/* src/pac_alpha.sv */
// Four-stage pipeline forming the effective alpha and the blend gate.
`default_nettype none
module pac_alpha (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         opacity_i,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire pac_pkg::pixel_in_t pix_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output pac_pkg::alpha_t         alpha_o
);

  typedef struct packed {
    logic [1:0]     kind;
    pac_pkg::rgba_t src;
    pac_pkg::rgba_t dest;
    logic [7:0]     mask;
    logic           sa_nz;
    logic           ma_nz;
    logic [15:0]    m_so;
    logic [15:0]    m_sm;
  } st1_t;

  typedef struct packed {
    logic [1:0]     kind;
    pac_pkg::rgba_t src;
    pac_pkg::rgba_t dest;
    logic [7:0]     mask;
    logic           sa_nz;
    logic           ma_nz;
    logic [7:0]     q_so;
    logic [23:0]    m_smo;
  } st2_t;

  typedef struct packed {
    logic [1:0]     kind;
    pac_pkg::rgba_t src;
    pac_pkg::rgba_t dest;
    logic           sa_nz;
    logic           ma_nz;
    logic [7:0]     q_so;
    logic [15:0]    m_mq;
    logic [23:0]    m_smo;
    logic [8:0]     q3_est;
  } st3_t;

  logic [3:0] v_q;
  logic [3:0] adv;

  st1_t            s1_q, s1_d;
  st2_t            s2_q, s2_d;
  st3_t            s3_q, s3_d;
  pac_pkg::alpha_t s4_q, s4_d;

  // Each stage takes new data when empty or when its successor advances.
  assign adv[3]  = ~v_q[3] | ready_i;
  assign adv[2]  = ~v_q[2] | adv[3];
  assign adv[1]  = ~v_q[1] | adv[2];
  assign adv[0]  = ~v_q[0] | adv[1];
  assign ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 4'd0;
    end else begin
      if (adv[0]) v_q[0] <= valid_i;
      if (adv[1]) v_q[1] <= v_q[0];
      if (adv[2]) v_q[2] <= v_q[1];
      if (adv[3]) v_q[3] <= v_q[2];
    end
  end

  // Stage 1: source alpha times opacity and times mask.
  always_comb begin
    s1_d.kind       = pix_i.kind;
    s1_d.src.red    = pix_i.src_red;
    s1_d.src.green  = pix_i.src_green;
    s1_d.src.blue   = pix_i.src_blue;
    s1_d.src.alpha  = pix_i.src_alpha;
    s1_d.dest.red   = pix_i.dest_red;
    s1_d.dest.green = pix_i.dest_green;
    s1_d.dest.blue  = pix_i.dest_blue;
    s1_d.dest.alpha = pix_i.dest_alpha;
    s1_d.mask       = pix_i.mask_alpha;
    s1_d.sa_nz      = (pix_i.src_alpha != 8'd0);
    s1_d.ma_nz      = (pix_i.mask_alpha != 8'd0);
    s1_d.m_so       = 16'(pix_i.src_alpha) * 16'(opacity_i);
    s1_d.m_sm       = 16'(pix_i.src_alpha) * 16'(pix_i.mask_alpha);
  end

  // Stage 2: divide by 255, and the triple product for the sampled brush.
  always_comb begin
    s2_d.kind  = s1_q.kind;
    s2_d.src   = s1_q.src;
    s2_d.dest  = s1_q.dest;
    s2_d.mask  = s1_q.mask;
    s2_d.sa_nz = s1_q.sa_nz;
    s2_d.ma_nz = s1_q.ma_nz;
    s2_d.q_so  = pac_pkg::div255(s1_q.m_so);
    s2_d.m_smo = 24'(s1_q.m_sm) * 24'(opacity_i);
  end

  // Stage 3: mask times scaled brush alpha, and the estimated quotient by 65025.
  logic [40:0] recip_prod;
  always_comb begin
    recip_prod  = 41'(s2_q.m_smo) * pac_pkg::Recip65025;
    s3_d.kind   = s2_q.kind;
    s3_d.src    = s2_q.src;
    s3_d.dest   = s2_q.dest;
    s3_d.sa_nz  = s2_q.sa_nz;
    s3_d.ma_nz  = s2_q.ma_nz;
    s3_d.q_so   = s2_q.q_so;
    s3_d.m_mq   = 16'(s2_q.mask) * 16'(s2_q.q_so);
    s3_d.m_smo  = s2_q.m_smo;
    s3_d.q3_est = recip_prod[40:32];
  end

  // Stage 4: correct the estimate, pick alpha and gate by kind.
  logic [24:0] back_prod;
  logic [8:0]  q3_fix;
  logic [7:0]  a_mask;
  always_comb begin
    back_prod = 25'(s3_q.q3_est) * pac_pkg::FullScaleSq;
    q3_fix    = (back_prod > 25'(s3_q.m_smo)) ? (s3_q.q3_est - 9'd1) : s3_q.q3_est;
    a_mask    = pac_pkg::div255(s3_q.m_mq);
    s4_d.src  = s3_q.src;
    s4_d.dest = s3_q.dest;
    case (s3_q.kind)
      pac_pkg::KIND_PAINT: begin
        s4_d.alpha  = s3_q.q_so;
        s4_d.active = (s3_q.q_so != 8'd0);
      end
      pac_pkg::KIND_COPY: begin
        s4_d.alpha  = s3_q.q_so;
        s4_d.active = s3_q.sa_nz;
      end
      pac_pkg::KIND_MASK_SOLID: begin
        s4_d.alpha  = a_mask;
        s4_d.active = s3_q.ma_nz;
      end
      default: begin
        s4_d.alpha  = q3_fix[7:0];
        s4_d.active = s3_q.ma_nz;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) s1_q <= s1_d;
    if (adv[1]) s2_q <= s2_d;
    if (adv[2]) s3_q <= s3_d;
    if (adv[3]) s4_q <= s4_d;
  end

  assign valid_o = v_q[3];
  assign alpha_o = s4_q;

endmodule
`default_nettype wire

/* src/pac_blend.sv */
// Two-stage per-channel blend and output selection.
`default_nettype none
module pac_blend (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire pac_pkg::alpha_t  alpha_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output pac_pkg::pixel_out_t   pix_o
);

  typedef struct packed {
    pac_pkg::rgba_t src;
    pac_pkg::rgba_t dest;
    logic [7:0]     alpha;
    logic           active;
    logic           replace;
    logic [15:0]    sum_r;
    logic [15:0]    sum_g;
    logic [15:0]    sum_b;
  } st5_t;

  logic [1:0] v_q;
  logic [1:0] adv;

  st5_t                s5_q, s5_d;
  pac_pkg::pixel_out_t s6_q, s6_d;

  assign adv[1]  = ~v_q[1] | ready_i;
  assign adv[0]  = ~v_q[0] | adv[1];
  assign ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 2'd0;
    end else begin
      if (adv[0]) v_q[0] <= valid_i;
      if (adv[1]) v_q[1] <= v_q[0];
    end
  end

  // Stage 5: weighted sums a*s + (255-a)*d per color channel.
  logic [7:0] inv_a;
  always_comb begin
    inv_a        = 8'(pac_pkg::FullScale) - alpha_i.alpha;
    s5_d.src     = alpha_i.src;
    s5_d.dest    = alpha_i.dest;
    s5_d.alpha   = alpha_i.alpha;
    s5_d.active  = alpha_i.active;
    s5_d.replace = (alpha_i.alpha == 8'(pac_pkg::FullScale));
    s5_d.sum_r   = 16'(alpha_i.alpha) * 16'(alpha_i.src.red)
                 + 16'(inv_a) * 16'(alpha_i.dest.red);
    s5_d.sum_g   = 16'(alpha_i.alpha) * 16'(alpha_i.src.green)
                 + 16'(inv_a) * 16'(alpha_i.dest.green);
    s5_d.sum_b   = 16'(alpha_i.alpha) * 16'(alpha_i.src.blue)
                 + 16'(inv_a) * 16'(alpha_i.dest.blue);
  end

  // Stage 6: scale down and choose skip, replace or blend.
  always_comb begin
    s6_d.changed = s5_q.active;
    if (!s5_q.active) begin
      s6_d.out_red   = s5_q.dest.red;
      s6_d.out_green = s5_q.dest.green;
      s6_d.out_blue  = s5_q.dest.blue;
      s6_d.out_alpha = s5_q.dest.alpha;
    end else if (s5_q.replace) begin
      s6_d.out_red   = s5_q.src.red;
      s6_d.out_green = s5_q.src.green;
      s6_d.out_blue  = s5_q.src.blue;
      s6_d.out_alpha = 8'(pac_pkg::FullScale);
    end else begin
      s6_d.out_red   = pac_pkg::div255(s5_q.sum_r);
      s6_d.out_green = pac_pkg::div255(s5_q.sum_g);
      s6_d.out_blue  = pac_pkg::div255(s5_q.sum_b);
      s6_d.out_alpha = (s5_q.dest.alpha > s5_q.alpha) ? s5_q.dest.alpha : s5_q.alpha;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) s5_q <= s5_d;
    if (adv[1]) s6_q <= s6_d;
  end

  assign valid_o = v_q[1];
  assign pix_o   = s6_q;

endmodule
`default_nettype wire

/* src/pixel_alpha_compositor_top.sv */
// Top level of the pixel alpha compositor.
//
// Composites one source/brush pixel over one destination pixel per transfer.
// pix_i carries the pixel pair, mask alpha and kind (paint, bitmap copy,
// mask with solid brush, mask with sampled brush); pix_o returns the new
// destination color and a changed flag. Both channels use valid/ready.
// The APB port holds the global opacity level (0..255) at byte address 0.
// Each pixel passes six registered stages from input to output transfer:
// four stages form the effective alpha (products, divide by 255, mask
// product, divide by 255 or by 65025 with one correction step) and two
// stages blend the color channels. Throughput is one pixel per clock while
// the receiver accepts output. When the receiver stalls, each stage holds
// its item and bubbles collapse, so input is still taken until all six
// stages are full. Reset empties the pipeline and sets the opacity level
// to 255.
// Write the opacity only while no pixel is in flight.
`default_nettype none
module pixel_alpha_compositor_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  pac_pix_in_if.sink       pix_i,
  pac_pix_out_if.source    pix_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [7:0]      opacity_lvl;
  logic            mid_valid;
  logic            mid_ready;
  pac_pkg::alpha_t mid_alpha;

  pac_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .opacity_o (opacity_lvl)
  );

  pac_alpha u_alpha (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .opacity_i (opacity_lvl),
    .valid_i   (pix_i.valid),
    .ready_o   (pix_i.ready),
    .pix_i     (pix_i.data),
    .valid_o   (mid_valid),
    .ready_i   (mid_ready),
    .alpha_o   (mid_alpha)
  );

  pac_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .alpha_i (mid_alpha),
    .valid_o (pix_o.valid),
    .ready_i (pix_o.ready),
    .pix_o   (pix_o.data)
  );

endmodule
`default_nettype wire
